@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL, included by matrix_multiply_3x3_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside of reset.
`define ASSERT_AT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the condition holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(name, clk, rst_n, cond, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_AT(name, clk, rst_n, prop, msg)
`define ASSERT_NEXT(name, clk, rst_n, cond, cons, msg)

`endif

`endif

@@ hw/rtl/mm3_pkg.sv @@
`default_nettype none

package mm3_pkg;

	// Width of one matrix element and of one product element.
	localparam int WORD_W = 32;

	// Default matrix dimension.
	localparam int DIM_DEF = 3;

	// Control that travels with each operand pair through the MAC pipeline.
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/matrix_multiply_3x3_unit.sv @@
`default_nettype none

// Streaming DIM x DIM integer matrix multiplier. Elements arrive one per transfer on the
// slave side, first DIM*DIM elements of A and then DIM*DIM elements of B, both row-major.
// After the last element of B the block computes C = A * B with a single shared 32 x 32
// multiply-accumulate unit, one product per cycle, and then drains the pipeline.
// The DIM*DIM elements of C then leave row-major on the master side at up to one per cycle,
// the last one marked with tlast; products and sums wrap modulo 2^32. The slave side is
// not ready during compute, drain and output, but loading of the next run starts as soon
// as the last element of C has been read from the product store, even while it still
// waits in the read stage or the output register.
module matrix_multiply_3x3_unit #(
	parameter int DIM = mm3_pkg::DIM_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// Slave side.
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [mm3_pkg::WORD_W-1:0]   s_tdata,   // [31:0] elem_value
	// Master side.
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [mm3_pkg::WORD_W-1:0]        m_tdata,   // [31:0] product_value
	output logic                              m_tlast    // last_flag
);
	import mm3_pkg::*;

	`include "assert_macros.svh"

	localparam int CELLS = DIM * DIM;
	localparam int AW    = $clog2(CELLS);
	localparam int IW    = $clog2(DIM);
	localparam int CW    = $clog2(2 * CELLS);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_CALC,
		ST_DRAIN,
		ST_OUT
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       load_count_q;

	// Compute sequencer.
	logic [IW-1:0]       k_q;
	logic [IW-1:0]       col_q;
	logic [IW-1:0]       row_q;
	logic [AW-1:0]       a_addr_q;
	logic [AW-1:0]       a_base_q;
	logic [AW-1:0]       b_addr_q;
	logic [AW-1:0]       c_addr_q;
	logic [AW-1:0]       c_addr_s1;
	logic [AW-1:0]       c_addr_s2;
	mac_ctl_t            ctl_s1;
	logic [WORD_W-1:0]   a_rd_s1;
	logic [WORD_W-1:0]   b_rd_s1;

	// Output path.
	logic [AW-1:0]       out_addr_q;
	logic [WORD_W-1:0]   crd_q;
	logic                crd_valid_q;
	logic                crd_last_q;
	logic                m_tvalid_q;
	logic [WORD_W-1:0]   m_tdata_q;
	logic                m_tlast_q;

	// Storage for A, B and the product.
	logic [WORD_W-1:0]   mem_a_q [CELLS];
	logic [WORD_W-1:0]   mem_b_q [CELLS];
	logic [WORD_W-1:0]   mem_c_q [CELLS];

	logic                in_xfer;
	logic                load_a;
	logic                load_b;
	logic                load_end;
	logic [AW-1:0]       ld_addr;
	logic                issue;
	logic                k_last;
	logic                col_last;
	logic                row_last;
	logic                mac_busy;
	logic                res_valid;
	logic [WORD_W-1:0]   res_value;
	logic                load_out;
	logic                rd_ok;
	logic                out_addr_last;

	// Load side decode.
	assign s_tready = (state_q == ST_LOAD);
	assign in_xfer  = s_tvalid & s_tready;
	assign load_a   = in_xfer & (load_count_q < CW'(CELLS));
	assign load_b   = in_xfer & (load_count_q >= CW'(CELLS));
	assign load_end = in_xfer & (load_count_q >= CW'(2 * CELLS - 1));
	assign ld_addr  = (load_count_q < CW'(CELLS)) ? load_count_q[AW-1:0]
		: AW'(load_count_q - CW'(CELLS));

	// Compute sequencer decode.
	assign issue    = (state_q == ST_CALC);
	assign k_last   = (k_q == IW'(DIM - 1));
	assign col_last = (col_q == IW'(DIM - 1));
	assign row_last = (row_q == IW'(DIM - 1));

	// Output decode: a read of the product store refills the one-entry read stage.
	assign load_out      = crd_valid_q & (~m_tvalid_q | m_tready);
	assign rd_ok         = (state_q == ST_OUT) & (~crd_valid_q | load_out);
	assign out_addr_last = (out_addr_q == AW'(CELLS - 1));

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	mm3_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.a_s1      (a_rd_s1),
		.b_s1      (b_rd_s1),
		.busy      (mac_busy),
		.res_valid (res_valid),
		.res_value (res_value)
	);

	// Operand stores, written while loading and read every cycle at the sequencer's addresses.
	always_ff @(posedge clk) begin
		if (load_a) begin
			mem_a_q[ld_addr] <= s_tdata;
		end
		if (load_b) begin
			mem_b_q[ld_addr] <= s_tdata;
		end
		a_rd_s1 <= mem_a_q[a_addr_q];
		b_rd_s1 <= mem_b_q[b_addr_q];
	end

	// Product store, written by the MAC and read by the output path.
	always_ff @(posedge clk) begin
		if (res_valid) begin
			mem_c_q[c_addr_s2] <= res_value;
		end
		if (rd_ok) begin
			crd_q <= mem_c_q[out_addr_q];
		end
	end

	// Sequencer, counters and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			load_count_q <= '0;
			k_q          <= '0;
			col_q        <= '0;
			row_q        <= '0;
			a_addr_q     <= '0;
			a_base_q     <= '0;
			b_addr_q     <= '0;
			c_addr_q     <= '0;
			c_addr_s1    <= '0;
			c_addr_s2    <= '0;
			ctl_s1       <= '0;
			out_addr_q   <= '0;
			crd_valid_q  <= 1'b0;
			crd_last_q   <= 1'b0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tlast_q    <= 1'b0;
		end else begin
			// Control for the read stage follows each issued operand pair.
			ctl_s1.valid <= issue;
			ctl_s1.first <= (k_q == '0);
			ctl_s1.last  <= k_last;
			c_addr_s1    <= c_addr_q;
			c_addr_s2    <= c_addr_s1;

			unique case (state_q)
				ST_LOAD: begin
					if (load_end) begin
						load_count_q <= '0;
						k_q          <= '0;
						col_q        <= '0;
						row_q        <= '0;
						a_addr_q     <= '0;
						a_base_q     <= '0;
						b_addr_q     <= '0;
						c_addr_q     <= '0;
						state_q      <= ST_CALC;
					end else if (in_xfer) begin
						load_count_q <= load_count_q + CW'(1);
					end
				end
				ST_CALC: begin
					// Walk k within a dot product, then columns, then rows.
					if (!k_last) begin
						k_q      <= k_q + IW'(1);
						a_addr_q <= a_addr_q + AW'(1);
						b_addr_q <= b_addr_q + AW'(DIM);
					end else begin
						k_q      <= '0;
						c_addr_q <= c_addr_q + AW'(1);
						if (!col_last) begin
							col_q    <= col_q + IW'(1);
							a_addr_q <= a_base_q;
							b_addr_q <= AW'(col_q) + AW'(1);
						end else begin
							col_q    <= '0;
							row_q    <= row_q + IW'(1);
							a_base_q <= a_base_q + AW'(DIM);
							a_addr_q <= a_base_q + AW'(DIM);
							b_addr_q <= '0;
							if (row_last) begin
								state_q <= ST_DRAIN;
							end
						end
					end
				end
				ST_DRAIN: begin
					if (!ctl_s1.valid && !mac_busy) begin
						out_addr_q <= '0;
						state_q    <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (rd_ok) begin
						out_addr_q <= out_addr_q + AW'(1);
						if (out_addr_last) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase

			// One-entry read stage between the product store and the output register.
			if (rd_ok) begin
				crd_valid_q <= 1'b1;
				crd_last_q  <= out_addr_last;
			end else if (load_out) begin
				crd_valid_q <= 1'b0;
			end

			// Output register: filled from the read stage, emptied by a transfer.
			if (load_out) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= crd_q;
				m_tlast_q  <= crd_last_q;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// The MAC pipeline is empty whenever elements are being loaded.
	`ASSERT_AT(a_load_mac_idle, clk, arst_n, !s_tready || (!ctl_s1.valid && !mac_busy), "MAC active while loading")
	// The final element of B starts the compute phase.
	`ASSERT_NEXT(a_last_load_calc, clk, arst_n, load_end, state_q == ST_CALC, "Compute did not start after last load")
	// Products are written back only during compute and drain.
	`ASSERT_AT(a_write_in_calc, clk, arst_n, !res_valid || state_q == ST_CALC || state_q == ST_DRAIN, "Product written outside compute")
	// A product read never happens while the pipeline still runs.
	`ASSERT_AT(a_read_after_drain, clk, arst_n, !rd_ok || (!ctl_s1.valid && !mac_busy), "Product read before drain")

endmodule

`default_nettype wire

@@ hw/rtl/mm3_mac.sv @@
`default_nettype none

module mm3_mac (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire mm3_pkg::mac_ctl_t            ctl_s1,
	input  wire logic [mm3_pkg::WORD_W-1:0]   a_s1,
	input  wire logic [mm3_pkg::WORD_W-1:0]   b_s1,
	output logic                              busy,
	output logic                              res_valid,
	output logic [mm3_pkg::WORD_W-1:0]        res_value
);
	import mm3_pkg::*;

	mac_ctl_t            ctl_s2;
	logic [WORD_W-1:0]   prod_s2;
	logic [WORD_W-1:0]   acc_q;
	logic [WORD_W-1:0]   prod_w;
	logic [WORD_W-1:0]   sum_w;

	// Only the low word of the product is kept, so signed and unsigned agree.
	assign prod_w = a_s1 * b_s1;

	// The first term of a dot product starts a fresh sum.
	assign sum_w = ctl_s2.first ? prod_s2 : acc_q + prod_s2;

	assign busy      = ctl_s2.valid;
	assign res_valid = ctl_s2.valid & ctl_s2.last;
	assign res_value = sum_w;

	// Control stage of the multiplier.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	// Product register and running sum.
	always_ff @(posedge clk) begin
		prod_s2 <= prod_w;
		if (ctl_s2.valid) begin
			acc_q <= sum_w;
		end
	end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mm3_pkg::*;

	localparam int N     = DIM_DEF;
	localparam int CELLS = N * N;
	localparam int LOADS = 2 * CELLS;

	// Cycle budget for the whole run, far above the slowest legal run.
	localparam int CYCLE_LIMIT = 200000;
	// Long back-pressure stretch on the master side.
	localparam int HOLD_CYCLES = 300;
	// Settling time after the last product leaves.
	localparam int DRAIN_CYCLES = 60;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct {
		word_t value;
		logic  last;
	} product_t;

	logic  clk;
	logic  arst_n;
	logic  s_tvalid;
	logic  s_tready;
	word_t s_tdata;   // [31:0] elem_value
	logic  m_tvalid;
	logic  m_tready;
	word_t m_tdata;   // [31:0] product_value
	logic  m_tlast;   // last_flag

	matrix_multiply_3x3_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Matrix operands as the block should hold them, and its load position.
	word_t    mat_a [CELLS];
	word_t    mat_b [CELLS];
	int       elems_loaded;
	product_t product_fifo [$];

	int  mismatches;
	int  cycle_count;
	int  send_idle_pct;
	int  recv_idle_pct;
	bit  hold_req;

	// Directed run: A is the identity with its top-left entry negated, so C is B with the
	// first row negated. B carries the word extremes; negating the most negative word wraps.
	word_t directed_elems [LOADS] = '{
		32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
		32'h0000_0000, 32'h0000_0001, 32'h0000_0000,
		32'h0000_0000, 32'h0000_0000, 32'h0000_0001,
		32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
		32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
		32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000
	};
	word_t directed_products [CELLS] = '{
		32'h8000_0000, 32'h8000_0001, 32'h0000_0001,
		32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
		32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000
	};

	// Clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Absorb one element; on the last element of B, produce the whole product matrix.
	task automatic absorb_element(input word_t v, output int count, output word_t prods [CELLS]);
		word_t acc;
		count = 0;
		if (elems_loaded < CELLS) begin
			mat_a[elems_loaded] = v;
			elems_loaded++;
		end else if (elems_loaded < LOADS - 1) begin
			mat_b[elems_loaded - CELLS] = v;
			elems_loaded++;
		end else begin
			mat_b[CELLS - 1] = v;
			elems_loaded = 0;
			for (int r = 0; r < N; r++) begin
				for (int c = 0; c < N; c++) begin
					acc = '0;
					for (int k = 0; k < N; k++) begin
						acc = acc + mat_a[r * N + k] * mat_b[k * N + c];
					end
					prods[r * N + c] = acc;
				end
			end
			count = CELLS;
		end
	endtask

	// Offer one element until it is taken, then record what it should produce.
	task automatic send_elem(input word_t v, input bit typed);
		int    count;
		word_t prods [CELLS];
		product_t p;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		absorb_element(v, count, prods);
		for (int i = 0; i < count; i++) begin
			p.value = typed ? directed_products[i] : prods[i];
			p.last  = (i == CELLS - 1);
			product_fifo.push_back(p);
		end
	endtask

	// Element values biased toward the extremes and small signed numbers.
	function automatic word_t pick_elem();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			4, 5: return word_t'($urandom_range(15)) - word_t'(8);
			default: return word_t'($urandom());
		endcase
	endfunction

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10) begin
			$display("[%0t] %s", $realtime, what);
		end
	endtask

	// Master-side ready, with random stalls and one long hold-off on request.
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Compare every product transfer with the oldest expectation.
	initial begin
		product_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (product_fifo.size() == 0) begin
					note_mismatch($sformatf("unexpected product %h last %b", m_tdata, m_tlast));
				end else begin
					want = product_fifo.pop_front();
					if (m_tdata !== want.value || m_tlast !== want.last) begin
						note_mismatch($sformatf("product %h last %b, expected %h last %b",
							m_tdata, m_tlast, want.value, want.last));
					end
				end
			end
		end
	end

	// Watchdog.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Reset, directed run, then three random phases with different idling.
	initial begin
		int phase_items [3] = '{144, 144, 162};
		int send_pct [3]    = '{23, 63, 0};
		int recv_pct [3]    = '{63, 23, 0};
		s_tvalid = 1'b0;
		s_tdata  = '0;
		arst_n   = 1'b0;
		hold_req = 1'b0;
		mismatches   = 0;
		elems_loaded = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		foreach (mat_a[i]) begin
			mat_a[i] = '0;
			mat_b[i] = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_elems[i]) begin
			send_elem(directed_elems[i], 1'b1);
		end

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = send_pct[ph];
			recv_idle_pct = recv_pct[ph];
			// Stall the output for a long stretch so the block backs up its input.
			if (ph == 2) begin
				hold_req = 1'b1;
			end
			for (int i = 0; i < phase_items[ph]; i++) begin
				send_elem(pick_elem(), 1'b0);
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (product_fifo.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (product_fifo.size() != 0) begin
			note_mismatch($sformatf("%0d products never arrived", product_fifo.size()));
		end

		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
